// ----- rtl/core/union_find_edge_acceptor_macros.svh -----
// assertion macros for the union-find edge acceptor
`ifndef UNION_FIND_EDGE_ACCEPTOR_MACROS_SVH
`define UNION_FIND_EDGE_ACCEPTOR_MACROS_SVH

// same-cycle implication, checked on clk, off while rst_n is low
`define UFEA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ufea check failed");

// next-cycle implication, checked on clk, off while rst_n is low
`define UFEA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ufea check failed");

`endif

// ----- rtl/core/ufea_pkg.sv -----
package ufea_pkg;

  localparam int NODES  = 1024;
  localparam int NODE_W = 10;
  localparam int CNT_W  = NODE_W + 1;
  localparam int COST_W = 32;
  localparam int SUM_W  = 48;

  localparam logic [CNT_W-1:0]  NODE_CNT  = CNT_W'(NODES);
  localparam logic [NODE_W-1:0] NODE_LAST = NODE_W'(NODES - 1);

  localparam logic ACT_CLEAR = 1'b0;

  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] addr;
    logic [NODE_W-1:0] wdata;
  } ufea_ram_req_t;

  typedef struct packed {
    logic clr;
    logic add;
  } ufea_sum_ctl_t;

endpackage

// ----- rtl/core/ufea_ram.sv -----
module ufea_ram
  import ufea_pkg::*;
(
  input  logic                 clk,
  input  ufea_ram_req_t        req,
  output logic [NODE_W-1:0]    rdata
);

  logic [NODE_W-1:0] mem [NODES];
  logic [NODE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata_r <= mem[req.addr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/ufea_sum.sv -----
module ufea_sum
  import ufea_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ufea_sum_ctl_t     ctl,
  input  logic [COST_W-1:0] cost,
  output logic [SUM_W-1:0]  total
);

  logic [SUM_W-1:0] sum_r;
  logic [SUM_W:0]   sum_ext;

  // carry out of the top bit means the total passed its maximum
  assign sum_ext = {1'b0, sum_r} + {{(SUM_W + 1 - COST_W){1'b0}}, cost};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ctl.clr) begin
      sum_r <= '0;
    end else if (ctl.add) begin
      sum_r <= sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
    end
  end

  assign total = sum_r;

endmodule

// ----- rtl/core/ufea_seq.sv -----
module ufea_seq
  import ufea_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_action,
  input  logic [NODE_W-1:0] in_node_a,
  input  logic [NODE_W-1:0] in_node_b,
  input  logic [COST_W-1:0] in_edge_cost,
  output logic              busy,
  output logic              out_valid,
  output logic              out_joined,
  output ufea_ram_req_t     ram_req,
  input  logic [NODE_W-1:0] ram_rdata,
  output ufea_sum_ctl_t     sum_ctl,
  output logic [COST_W-1:0] cost
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FRD,
    S_FCHK,
    S_CRD,
    S_CWR,
    S_JOIN,
    S_DONE
  } state_t;

  state_t            state_r;
  logic [NODE_W-1:0] cur_r;
  logic [NODE_W-1:0] root_r;
  logic [NODE_W-1:0] ra_r;
  logic [NODE_W-1:0] a_r;
  logic [NODE_W-1:0] b_r;
  logic [COST_W-1:0] cost_r;
  logic              side_r;
  logic              clr_item_r;
  logic              out_valid_r;
  logic              out_joined_r;

  logic [NODE_W-1:0] cmp_x;
  logic [NODE_W-1:0] cmp_y;
  logic              cmp_eq;
  logic              cmp_lt;
  logic              in_range;

  // shared node comparator, operands picked by state
  always_comb begin
    unique case (state_r)
      S_FCHK: begin
        cmp_x = ram_rdata;
        cmp_y = cur_r;
      end
      S_JOIN: begin
        cmp_x = ra_r;
        cmp_y = root_r;
      end
      default: begin
        cmp_x = cur_r;
        cmp_y = root_r;
      end
    endcase
  end

  assign cmp_eq = (cmp_x == cmp_y);
  assign cmp_lt = (cmp_x < cmp_y);

  assign in_range = ({1'b0, in_node_a} < NODE_CNT) && ({1'b0, in_node_b} < NODE_CNT);

  always_comb begin
    ram_req.we    = 1'b0;
    ram_req.addr  = cur_r;
    ram_req.wdata = root_r;
    sum_ctl.clr   = 1'b0;
    sum_ctl.add   = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.wdata = cur_r;
        sum_ctl.clr   = 1'b1;
      end
      S_CWR: begin
        ram_req.we = 1'b1;
      end
      S_JOIN: begin
        // larger root gets the smaller one as parent
        if (!cmp_eq) begin
          ram_req.we    = 1'b1;
          ram_req.addr  = cmp_lt ? root_r : ra_r;
          ram_req.wdata = cmp_lt ? ra_r : root_r;
          sum_ctl.add   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      cur_r        <= '0;
      side_r       <= 1'b0;
      clr_item_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      out_joined_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          cur_r <= cur_r + NODE_W'(1);
          if (cur_r == NODE_LAST) begin
            state_r      <= S_IDLE;
            out_valid_r  <= clr_item_r;
            out_joined_r <= 1'b0;
            clr_item_r   <= 1'b0;
          end
        end
        S_IDLE: begin
          if (start) begin
            a_r    <= in_node_a;
            b_r    <= in_node_b;
            cost_r <= in_edge_cost;
            side_r <= 1'b0;
            if (in_action == ACT_CLEAR) begin
              cur_r      <= '0;
              clr_item_r <= 1'b1;
              state_r    <= S_CLEAR;
            end else if (in_range) begin
              cur_r   <= in_node_a;
              state_r <= S_FRD;
            end else begin
              out_joined_r <= 1'b0;
              state_r      <= S_DONE;
            end
          end
        end
        S_FRD: begin
          state_r <= S_FCHK;
        end
        S_FCHK: begin
          if (cmp_eq) begin
            root_r  <= cur_r;
            cur_r   <= side_r ? b_r : a_r;
            state_r <= S_CRD;
          end else begin
            cur_r   <= ram_rdata;
            state_r <= S_FRD;
          end
        end
        S_CRD: begin
          if (cmp_eq) begin
            if (!side_r) begin
              ra_r    <= root_r;
              side_r  <= 1'b1;
              cur_r   <= b_r;
              state_r <= S_FRD;
            end else begin
              state_r <= S_JOIN;
            end
          end else begin
            state_r <= S_CWR;
          end
        end
        S_CWR: begin
          cur_r   <= ram_rdata;
          state_r <= S_CRD;
        end
        S_JOIN: begin
          out_joined_r <= !cmp_eq;
          state_r      <= S_DONE;
        end
        S_DONE: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_joined = out_joined_r;
  assign cost       = cost_r;

endmodule

// ----- rtl/core/union_find_edge_acceptor.sv -----
// kruskal edge acceptor on a disjoint-set forest of 1024 nodes
// input: a word is taken when start is high and busy is low; in_action
//   low clears the forest and the running total, high offers the edge
//   in_node_a / in_node_b with cost in_edge_cost (16 fraction bits)
// output: one word per input word, out_valid high for one cycle with
//   out_joined and out_total_cost; the receiver cannot hold it off
// an edge walks both parent chains through one single-port parent memory
//   with one shared node comparator: each chain step while finding a root
//   reads the parent (S_FRD) and checks it (S_FCHK), and each node on the
//   path is then read (S_CRD) and rewritten (S_CWR) to point at the root
// a clear sweeps the parent memory one entry a cycle
// edges with an endpoint not below the node count go to the done state
//   at once and give a result with out_joined low and the total unchanged
// the total saturates at its 48-bit maximum
// after reset the same clearing pass runs with busy high and no result
//   word; a result's out_valid shows in the first cycle busy is low again
module union_find_edge_acceptor
  import ufea_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_action,
  input  logic [NODE_W-1:0] in_node_a,
  input  logic [NODE_W-1:0] in_node_b,
  input  logic [COST_W-1:0] in_edge_cost,
  output logic              out_valid,
  output logic              out_joined,
  output logic [SUM_W-1:0]  out_total_cost
);

`include "union_find_edge_acceptor_macros.svh"

  ufea_ram_req_t     ram_req;
  logic [NODE_W-1:0] ram_rdata;
  ufea_sum_ctl_t     sum_ctl;
  logic [COST_W-1:0] cost;

  ufea_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_action    (in_action),
    .in_node_a    (in_node_a),
    .in_node_b    (in_node_b),
    .in_edge_cost (in_edge_cost),
    .busy         (busy),
    .out_valid    (out_valid),
    .out_joined   (out_joined),
    .ram_req      (ram_req),
    .ram_rdata    (ram_rdata),
    .sum_ctl      (sum_ctl),
    .cost         (cost)
  );

  ufea_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  ufea_sum u_sum (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (sum_ctl),
    .cost  (cost),
    .total (out_total_cost)
  );

  `UFEA_ASSERT_NOW(a_result_when_idle, out_valid, !busy)
  `UFEA_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy)
  `UFEA_ASSERT_NEXT(a_clear_zeroes_total, sum_ctl.clr, out_total_cost == '0)

endmodule
